### sv/wpm_pkg.sv
// Shared types and constants for the wildcard pattern matcher.
`timescale 1ns / 1ps

package wpm_pkg;

  localparam logic [7:0] STAR_BYTE  = 8'h2A;
  localparam logic [7:0] QUERY_BYTE = 8'h3F;

  typedef enum logic [1:0] {
    OP_NEW_PATTERN = 2'd0,
    OP_APPEND      = 2'd1,
    OP_TEXT        = 2'd2,
    OP_START_TEXT  = 2'd3
  } wpm_op_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_in;
  } wpm_in_t;

  typedef struct packed {
    logic match;
    logic pattern_overflow;
  } wpm_out_t;

  // Per-cycle control broadcast to every cell of the row.
  typedef struct packed {
    logic       restart;
    logic       advance;
    logic [7:0] text_char;
  } wpm_ctrl_t;

endpackage

### sv/wpm_if.sv
// Valid/ready channel interfaces for the matcher's item and result streams.
`timescale 1ns / 1ps

interface wpm_in_if;
  import wpm_pkg::*;

  logic    valid;
  logic    ready;
  wpm_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wpm_out_if;
  import wpm_pkg::*;

  logic     valid;
  logic     ready;
  wpm_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/wpm_cell.sv
// One pattern position: stored pattern byte and its match bit in the rolling row.
`timescale 1ns / 1ps

module wpm_cell (
  input  logic              clk,
  input  logic              rst,
  input  wpm_pkg::wpm_ctrl_t ctrl,
  input  logic              load,
  input  logic [7:0]        pat_byte,
  input  logic              active,
  input  logic              init_bit,
  input  logic              diag_in,
  input  logic              left_in,
  output logic              up,
  output logic              left_out
);
  import wpm_pkg::*;

  logic [7:0] pat;
  logic       row;
  logic       bit_next;

  always_comb begin
    if (!active) begin
      bit_next = 1'b0;
    end else if (pat == STAR_BYTE) begin
      bit_next = row | left_in;
    end else if (pat == QUERY_BYTE || pat == ctrl.text_char) begin
      bit_next = diag_in;
    end else begin
      bit_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pat <= pat_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= 1'b0;
    end else if (ctrl.restart) begin
      row <= init_bit;
    end else if (ctrl.advance) begin
      row <= bit_next;
    end
  end

  assign up       = row;
  assign left_out = bit_next;

endmodule

### sv/wildcard_pattern_matcher.sv
// Top level of the streaming glob matcher ('?' one byte, '*' any run).
`timescale 1ns / 1ps

// Matches a byte stream against a stored glob pattern of up to MAX_PATTERN bytes.
// Each pattern position is a cell holding its byte and one match bit; a text byte
// updates the whole row together, with the '*' run bits rippling from cell to
// cell, and a new transaction is accepted each cycle as long as the result
// register is free or being drained. Opcodes 0 (new pattern) and 1 (append
// byte) restart the text and give no result; opcodes 2 (text byte) and 3 (new
// text) give one registered result in the cycle after they are accepted.
// Bytes appended beyond MAX_PATTERN are dropped and set the sticky overflow bit.
module wildcard_pattern_matcher #(
  parameter int MAX_PATTERN = 64
) (
  input  logic clk,
  input  logic rst,
  wpm_in_if.sink    items,
  wpm_out_if.source results
);
  import wpm_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [LEN_W-1:0] len, len_next;
  logic [LEN_W-1:0] lsc, lsc_next;
  logic             all_stars, all_stars_next;
  logic             row_origin;
  logic             ovf, ovf_next;
  logic             out_valid;
  wpm_out_t         out_data;

  logic             accept;
  logic [1:0]       op;
  logic [7:0]       ch;
  logic             append_ok;
  logic             append_we;
  wpm_ctrl_t        ctrl;
  logic [IDX_W-1:0] last_idx;
  logic             match_next;

  logic [MAX_PATTERN-1:0] up;
  logic [MAX_PATTERN-1:0] bits;
  logic [MAX_PATTERN-1:0] init_bits;

  assign items.ready = !out_valid || results.ready;
  assign accept      = items.valid && items.ready;
  assign op          = items.data.opcode;
  assign ch          = items.data.char_in;
  assign append_ok   = len < LEN_W'(MAX_PATTERN);
  assign append_we   = accept && op == OP_APPEND && append_ok;

  assign ctrl.restart   = accept && op != OP_TEXT;
  assign ctrl.advance   = accept && op == OP_TEXT;
  assign ctrl.text_char = ch;

  always_comb begin
    len_next       = len;
    lsc_next       = lsc;
    all_stars_next = all_stars;
    ovf_next       = ovf;
    if (op == OP_NEW_PATTERN) begin
      len_next       = '0;
      lsc_next       = '0;
      all_stars_next = 1'b1;
      ovf_next       = 1'b0;
    end else if (op == OP_APPEND) begin
      if (append_ok) begin
        len_next = len + 1'b1;
        if (ch == STAR_BYTE && all_stars) begin
          lsc_next = lsc + 1'b1;
        end else begin
          all_stars_next = 1'b0;
        end
      end else begin
        ovf_next = 1'b1;
      end
    end
  end

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic diag_in;
    logic left_in;

    if (j == 0) begin : g_first
      assign diag_in = row_origin;
      assign left_in = 1'b0;
    end else begin : g_rest
      assign diag_in = up[j-1];
      assign left_in = bits[j-1];
    end

    assign init_bits[j] = lsc_next > LEN_W'(j);

    wpm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .load     (append_we && len == LEN_W'(j)),
      .pat_byte (ch),
      .active   (len > LEN_W'(j)),
      .init_bit (init_bits[j]),
      .diag_in  (diag_in),
      .left_in  (left_in),
      .up       (up[j]),
      .left_out (bits[j])
    );
  end

  assign last_idx = IDX_W'(len - 1'b1);

  always_comb begin
    if (op == OP_TEXT) begin
      match_next = (len == '0) ? 1'b0 : bits[last_idx];
    end else begin
      match_next = (len == '0) ? 1'b1 : init_bits[last_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len        <= '0;
      lsc        <= '0;
      all_stars  <= 1'b1;
      row_origin <= 1'b1;
      ovf        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        len       <= len_next;
        lsc       <= lsc_next;
        all_stars <= all_stars_next;
        ovf       <= ovf_next;
      end
      if (ctrl.restart) begin
        row_origin <= 1'b1;
      end else if (ctrl.advance) begin
        row_origin <= 1'b0;
      end
      if (accept && (op == OP_TEXT || op == OP_START_TEXT)) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (op == OP_TEXT || op == OP_START_TEXT)) begin
      out_data.match            <= match_next;
      out_data.pattern_overflow <= ovf;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_data;

endmodule

### bench/testbench.sv
// Self-checking testbench for the wildcard pattern matcher: random glob sessions, random stalls.
`timescale 1ns / 1ps

module testbench;
  import wpm_pkg::*;

  localparam int MAX_PATTERN = 64;
  localparam int ITEM_TARGET = 1850;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic clk;
  logic rst;

  wpm_in_if  items ();
  wpm_out_if results ();

  wildcard_pattern_matcher #(
    .MAX_PATTERN(MAX_PATTERN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .items(items),
    .results(results)
  );

  wpm_in_t  pending_items[$];
  wpm_out_t expected_verdicts[$];

  logic [7:0]  pat_bytes[MAX_PATTERN];
  int unsigned pat_len;
  int unsigned star_lead;
  bit          only_stars;
  bit          empty_prefix;
  bit          ovf_seen;
  logic [63:0] match_row;

  int  mismatches;
  int  stall_cycles;
  int  drv_wait;
  int  sink_wait;
  bit  drv_calm;
  bit  sink_calm;
  bit  drv_free;
  bit  got_result;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic restart_text();
    empty_prefix = 1'b1;
    match_row = (star_lead >= 64) ? '1 : ((64'd1 << star_lead) - 64'd1);
  endtask

  task automatic track_item(input wpm_in_t it);
    logic [63:0] next_row;
    logic left_hit, diag_hit, up_hit, cell_hit;
    wpm_out_t verdict;
    case (wpm_op_t'(it.opcode))
      OP_NEW_PATTERN: begin
        pat_len = 0;
        star_lead = 0;
        only_stars = 1'b1;
        ovf_seen = 1'b0;
        restart_text();
      end
      OP_APPEND: begin
        if (pat_len < MAX_PATTERN) begin
          pat_bytes[pat_len] = it.char_in;
          pat_len++;
          if (it.char_in == STAR_BYTE && only_stars) star_lead++;
          else only_stars = 1'b0;
        end else begin
          ovf_seen = 1'b1;
        end
        restart_text();
      end
      OP_TEXT: begin
        next_row = '0;
        left_hit = 1'b0;
        diag_hit = empty_prefix;
        for (int j = 0; j < pat_len; j++) begin
          up_hit = match_row[j];
          if (pat_bytes[j] == STAR_BYTE) cell_hit = up_hit | left_hit;
          else if (pat_bytes[j] == QUERY_BYTE || pat_bytes[j] == it.char_in) cell_hit = diag_hit;
          else cell_hit = 1'b0;
          next_row[j] = cell_hit;
          left_hit = cell_hit;
          diag_hit = up_hit;
        end
        match_row = next_row;
        empty_prefix = 1'b0;
      end
      default: restart_text();
    endcase
    if (it.opcode == OP_TEXT || it.opcode == OP_START_TEXT) begin
      verdict.match = (pat_len == 0) ? empty_prefix : match_row[pat_len - 1];
      verdict.pattern_overflow = ovf_seen;
      expected_verdicts.push_back(verdict);
    end
  endtask

  function automatic void push_item(input wpm_op_t op, input logic [7:0] ch);
    wpm_in_t it;
    it.opcode = op;
    it.char_in = ch;
    pending_items.push_back(it);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return STAR_BYTE;
    if (r < 50) return QUERY_BYTE;
    if (r < 70) return 8'h61;
    if (r < 90) return 8'h62;
    return 8'($urandom_range(0, 255));
  endfunction

  // Driver: one transaction per draw, random gap before the next one.
  always @(posedge clk) begin
    if (rst) begin
      items.valid <= 1'b0;
      items.data <= '0;
      drv_wait = 0;
      pat_len = 0;
      star_lead = 0;
      only_stars = 1'b1;
      ovf_seen = 1'b0;
      empty_prefix = 1'b1;
      match_row = '0;
    end else begin
      drv_free = !items.valid;
      if (items.valid && items.ready) begin
        track_item(items.data);
        drv_free = 1'b1;
      end
      if (drv_free) begin
        if (drv_wait > 0) begin
          drv_wait--;
          items.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          items.data <= pending_items.pop_front();
          items.valid <= 1'b1;
          if ($urandom_range(0, 63) == 0) drv_calm = !drv_calm;
          drv_wait = drv_calm ? 0 : $urandom_range(0, 18);
        end else begin
          items.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction, random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
      sink_wait = 0;
    end else begin
      got_result = results.valid && results.ready;
      if (got_result) begin
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: match %b overflow %b",
                     results.data.match, results.data.pattern_overflow);
        end else begin
          wpm_out_t exp_v;
          exp_v = expected_verdicts.pop_front();
          if (exp_v.match !== results.data.match ||
              exp_v.pattern_overflow !== results.data.pattern_overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: match exp %b got %b, overflow exp %b got %b",
                       exp_v.match, results.data.match,
                       exp_v.pattern_overflow, results.data.pattern_overflow);
          end
        end
        if ($urandom_range(0, 63) == 0) sink_calm = !sink_calm;
        sink_wait = sink_calm ? 0 : $urandom_range(0, 18);
      end
      if (sink_wait > 0) begin
        sink_wait--;
        results.ready <= 1'b0;
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (items.valid && items.ready) || (results.valid && results.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [7:0] gen_pat[$];
    int queued;
    int plen;
    int r;
    int n_texts;
    int tlen;
    logic [7:0] ch;

    rst = 1'b1;
    items.valid = 1'b0;
    items.data = '0;
    results.ready = 1'b0;
    mismatches = 0;
    stall_cycles = 0;
    drv_calm = 1'b0;
    sink_calm = 1'b0;

    // Directed: empty pattern, wildcards, mid-text append, extreme bytes, literal '*'/'?' in text.
    push_item(OP_TEXT, 8'h61);
    push_item(OP_START_TEXT, 8'hFF);
    push_item(OP_NEW_PATTERN, 8'hA5);
    push_item(OP_APPEND, STAR_BYTE);
    push_item(OP_APPEND, 8'h61);
    push_item(OP_APPEND, QUERY_BYTE);
    push_item(OP_START_TEXT, 8'h00);
    push_item(OP_TEXT, 8'h78);
    push_item(OP_TEXT, 8'h61);
    push_item(OP_TEXT, STAR_BYTE);
    push_item(OP_TEXT, 8'hFF);
    push_item(OP_APPEND, STAR_BYTE);
    push_item(OP_TEXT, 8'h61);
    push_item(OP_TEXT, 8'h62);
    push_item(OP_NEW_PATTERN, 8'h5A);
    push_item(OP_APPEND, 8'h00);
    push_item(OP_APPEND, 8'hFF);
    push_item(OP_TEXT, 8'h00);
    push_item(OP_TEXT, 8'hFF);
    push_item(OP_NEW_PATTERN, 8'h00);
    push_item(OP_APPEND, 8'h78);
    push_item(OP_TEXT, STAR_BYTE);
    push_item(OP_START_TEXT, 8'h3C);
    push_item(OP_TEXT, QUERY_BYTE);
    push_item(OP_START_TEXT, 8'hC3);
    queued = pending_items.size();

    while (queued < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // noise
        repeat ($urandom_range(1, 6)) begin
          push_item(wpm_op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          queued++;
        end
      end else begin
        if ($urandom_range(0, 9) != 0) begin
          push_item(OP_NEW_PATTERN, 8'($urandom_range(0, 255)));
          queued++;
          gen_pat.delete();
        end
        r = $urandom_range(0, 99);
        if (r < 85) plen = $urandom_range(0, 8);
        else if (r < 95) plen = $urandom_range(9, 40);
        else plen = $urandom_range(60, 70);
        repeat (plen) begin
          ch = pick_byte();
          gen_pat.push_back(ch);
          push_item(OP_APPEND, ch);
          queued++;
        end
        n_texts = $urandom_range(1, 4);
        repeat (n_texts) begin
          push_item(OP_START_TEXT, 8'($urandom_range(0, 255)));
          queued++;
          if ($urandom_range(0, 1) == 0) begin
            // text built to fit the pattern, with an occasional corruption
            foreach (gen_pat[j]) begin
              if (gen_pat[j] == STAR_BYTE) begin
                repeat ($urandom_range(0, 2)) begin
                  push_item(OP_TEXT, pick_byte());
                  queued++;
                end
              end else begin
                ch = (gen_pat[j] == QUERY_BYTE) ? 8'($urandom_range(0, 255)) : gen_pat[j];
                if ($urandom_range(0, 19) == 0) ch = pick_byte();
                push_item(OP_TEXT, ch);
                queued++;
              end
            end
          end else begin
            tlen = $urandom_range(0, 14);
            repeat (tlen) begin
              if ($urandom_range(0, 24) == 0) begin
                ch = pick_byte();
                gen_pat.push_back(ch);
                push_item(OP_APPEND, ch);
              end else begin
                push_item(OP_TEXT, pick_byte());
              end
              queued++;
            end
          end
        end
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || items.valid || expected_verdicts.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### wildcard_pattern_matcher.f
sv/wpm_pkg.sv
sv/wpm_if.sv
sv/wpm_cell.sv
sv/wildcard_pattern_matcher.sv
bench/testbench.sv
